/* src/card_access_list_unit_assert.svh */
// Assertion macros used by the checker file.
`ifndef CARD_ACCESS_LIST_UNIT_ASSERT_SVH
`define CARD_ACCESS_LIST_UNIT_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define CAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("card access list check failed");

// Next-cycle implication, quiet during reset.
`define CAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("card access list check failed");

`endif

/* src/cal_pkg.sv */
`default_nettype none
package cal_pkg;

  localparam int unsigned CAL_MAX_CARDS = 32;
  localparam int unsigned UID_W         = 32;

  localparam logic [1:0] OP_MATCH  = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_ADMIN    = 2'd1;
  localparam logic [1:0] KIND_APPROVED = 2'd2;

  localparam logic [7:0] ADMIN_UNSET_BYTE = 8'hFF;

  typedef struct packed {
    logic [1:0]       op;
    logic [UID_W-1:0] uid;
    logic [4:0]       entry_index;
  } cal_req_t;

  typedef struct packed {
    logic             ok;
    logic [1:0]       match_kind;
    logic [4:0]       match_index;
    logic [5:0]       card_count;
    logic [UID_W-1:0] entry_uid;
    logic             list_full;
  } cal_rsp_t;

  // Ring control from the sequencer to the cell chain.
  typedef struct packed {
    logic             shift;
    logic             sub_sel;
    logic [UID_W-1:0] sub_data;
  } cal_ring_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE
  } cal_state_t;

endpackage
`default_nettype wire

/* src/cal_cell.sv */
`default_nettype none
module cal_cell
  import cal_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             shift,
  input  wire logic [UID_W-1:0] d,
  output logic      [UID_W-1:0] q
);

  logic [UID_W-1:0] id_reg;

  always_ff @(posedge clk) begin
    if (shift) begin
      id_reg <= d;
    end
  end

  assign q = id_reg;

endmodule
`default_nettype wire

/* src/cal_ring.sv */
`default_nettype none
module cal_ring
  import cal_pkg::*;
#(
  parameter int unsigned MAX_CARDS = CAL_MAX_CARDS
) (
  input  wire logic             clk,
  input  wire cal_ring_ctl_t    ctl,
  output logic      [UID_W-1:0] head
);

  logic [UID_W-1:0] cell_q [MAX_CARDS];
  logic [UID_W-1:0] cell_d [MAX_CARDS];

  // Each cell takes its upper neighbor; the head wraps to the tail, or the
  // substitute value goes in its place.
  for (genvar i = 0; i < MAX_CARDS; i++) begin : g_cell
    if (i == MAX_CARDS - 1) begin : g_tail
      assign cell_d[i] = ctl.sub_sel ? ctl.sub_data : cell_q[0];
    end else begin : g_body
      assign cell_d[i] = cell_q[i+1];
    end

    cal_cell u_cell (
      .clk   (clk),
      .shift (ctl.shift),
      .d     (cell_d[i]),
      .q     (cell_q[i])
    );
  end

  assign head = cell_q[0];

endmodule
`default_nettype wire

/* src/cal_ctrl.sv */
`default_nettype none
module cal_ctrl
  import cal_pkg::*;
#(
  parameter int unsigned MAX_CARDS = CAL_MAX_CARDS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire cal_req_t         req,
  input  wire logic [UID_W-1:0] head,
  output cal_ring_ctl_t         ring_ctl,
  output logic                  done,
  output cal_rsp_t              rsp
);

  localparam int unsigned KW = $clog2(MAX_CARDS);
  localparam int unsigned CW = $clog2(MAX_CARDS + 1);
  localparam int unsigned IW = (CW > 5) ? CW : 5;

  cal_state_t       state, state_next;
  cal_req_t         cmd;
  logic [KW-1:0]    k;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [UID_W-1:0] admin_id;
  logic [UID_W-1:0] admin_next;
  logic             hit;
  logic [KW-1:0]    pos;
  logic [UID_W-1:0] last_id;
  logic [UID_W-1:0] rd_id;
  logic [KW-1:0]    target;
  logic [UID_W-1:0] sub_id;

  logic             k_last;
  logic             k_valid;
  logic             admin_hit;
  logic             idx_valid;
  logic             dec_upd;
  logic [KW-1:0]    dec_target;
  logic [UID_W-1:0] dec_data;
  cal_rsp_t         dec_rsp;

  assign k_last    = (k == KW'(MAX_CARDS - 1));
  assign k_valid   = (CW'(k) < count);
  assign admin_hit = (admin_id == cmd.uid);
  assign idx_valid = (IW'(cmd.entry_index) < IW'(count));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (k_last) state_next = ST_DECIDE;
      ST_DECIDE: state_next = dec_upd ? ST_UPDATE : ST_IDLE;
      ST_UPDATE: if (k_last) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy              = (state != ST_IDLE);
    ring_ctl.shift    = (state == ST_SCAN) || (state == ST_UPDATE);
    ring_ctl.sub_sel  = (state == ST_UPDATE) && (k == target);
    ring_ctl.sub_data = sub_id;
  end

  // Outcome of a request once the scan has seen every entry.
  always_comb begin
    dec_rsp    = '0;
    dec_upd    = 1'b0;
    dec_target = pos;
    dec_data   = last_id;
    count_next = count;
    admin_next = admin_id;
    case (cmd.op)
      OP_MATCH: begin
        if (admin_hit) begin
          dec_rsp.ok         = 1'b1;
          dec_rsp.match_kind = KIND_ADMIN;
        end else if (hit) begin
          dec_rsp.ok          = 1'b1;
          dec_rsp.match_kind  = KIND_APPROVED;
          dec_rsp.match_index = 5'(pos);
        end
      end
      OP_ADD: begin
        if (admin_id[7:0] == ADMIN_UNSET_BYTE) begin
          admin_next = cmd.uid;
          dec_rsp.ok = 1'b1;
        end else if (admin_hit || hit) begin
          dec_rsp.ok = 1'b0;
        end else if (count == CW'(MAX_CARDS)) begin
          dec_rsp.list_full = 1'b1;
        end else begin
          dec_upd    = 1'b1;
          dec_target = KW'(count);
          dec_data   = cmd.uid;
          count_next = count + CW'(1);
          dec_rsp.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        // Move the last entry into the freed slot.
        if (!admin_hit && hit) begin
          dec_upd    = 1'b1;
          count_next = count - CW'(1);
          dec_rsp.ok = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_valid) begin
          dec_rsp.ok        = 1'b1;
          dec_rsp.entry_uid = rd_id;
        end
      end
      default: dec_rsp = '0;
    endcase
    dec_rsp.card_count = 6'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      admin_id <= '1;
      done     <= 1'b0;
      k        <= '0;
    end else begin
      state <= state_next;
      done  <= ((state == ST_DECIDE) && !dec_upd) || ((state == ST_UPDATE) && k_last);
      if (ring_ctl.shift) begin
        k <= k_last ? '0 : k + KW'(1);
      end
      if (state == ST_DECIDE) begin
        count    <= count_next;
        admin_id <= admin_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd     <= req;
          hit     <= 1'b0;
          pos     <= '0;
          last_id <= '0;
          rd_id   <= '0;
        end
      end
      ST_SCAN: begin
        // Head holds entry k; keep only the first hit.
        if (k_valid && !hit && (head == cmd.uid)) begin
          hit <= 1'b1;
          pos <= k;
        end
        if ((CW'(k) + CW'(1)) == count) begin
          last_id <= head;
        end
        if (k_valid && (IW'(k) == IW'(cmd.entry_index))) begin
          rd_id <= head;
        end
      end
      ST_DECIDE: begin
        rsp    <= dec_rsp;
        target <= dec_target;
        sub_id <= dec_data;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

/* src/card_access_list_unit.sv */
// Card access list: one admin ID plus a list of up to MAX_CARDS approved IDs
// held in a ring of cells that rotates one entry per cycle while a request is
// scanned or updated. A request is taken when start is high and busy is low.
// Match, read, an add that sets the admin and any refused add or remove make
// one full turn of the ring, then a decision state, then the result. An add
// that appends or a remove that frees a slot takes a second turn after the
// decision. The result is on rsp while done is high for exactly one cycle,
// and busy is already low in that cycle. The receiver cannot stall it and
// must capture it in that cycle.
`default_nettype none
module card_access_list_unit
  import cal_pkg::*;
#(
  parameter int unsigned MAX_CARDS = CAL_MAX_CARDS
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire cal_req_t req,
  output logic          done,
  output cal_rsp_t      rsp
);

  cal_ring_ctl_t    ring_ctl;
  logic [UID_W-1:0] head;

  cal_ctrl #(
    .MAX_CARDS (MAX_CARDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .head     (head),
    .ring_ctl (ring_ctl),
    .done     (done),
    .rsp      (rsp)
  );

  cal_ring #(
    .MAX_CARDS (MAX_CARDS)
  ) u_ring (
    .clk  (clk),
    .ctl  (ring_ctl),
    .head (head)
  );

endmodule
`default_nettype wire

/* src/cal_checker.sv */
`default_nettype none
`include "card_access_list_unit_assert.svh"
module cal_checker
  import cal_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input wire cal_rsp_t rsp
);

  logic accept;
  assign accept = start && !busy;

  `CAL_ASSERT_NEXT(a_busy_after_accept, accept, busy)
  `CAL_ASSERT_NEXT(a_no_instant_result, accept, !done)
  `CAL_ASSERT_NOW(a_full_not_ok, done && rsp.list_full, !rsp.ok)
  `CAL_ASSERT_NOW(a_kind_means_ok, done && (rsp.match_kind != KIND_NONE), rsp.ok)

endmodule

bind card_access_list_unit cal_checker u_cal_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top
  import cal_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] ADMIN_CARD = 32'hC0FFEE01;
  localparam int unsigned RANDOM_REQUESTS = 1700;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} mix_phase_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  cal_req_t req = '0;
  logic     done;
  cal_rsp_t rsp;

  cal_req_t    req_q[$];
  cal_rsp_t    pending_rsps[$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  bit          offering = 1'b0;

  // Shadow copy of the access list
  logic [31:0] admin_uid;
  logic [31:0] card_ids[CAL_MAX_CARDS];
  int unsigned card_total;

  card_access_list_unit DUT (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [1:0] find_card(input logic [31:0] id, output logic [4:0] at);
    at = '0;
    if (admin_uid == id) return KIND_ADMIN;
    for (int unsigned i = 0; i < card_total; i++) begin
      if (card_ids[i] == id) begin
        at = i[4:0];
        return KIND_APPROVED;
      end
    end
    return KIND_NONE;
  endfunction

  function automatic cal_rsp_t apply_card_request(input cal_req_t r);
    cal_rsp_t   o;
    logic [1:0] kind;
    logic [4:0] at;
    o = '0;
    case (r.op)
      OP_MATCH: begin
        kind = find_card(r.uid, at);
        o.match_kind = kind;
        o.match_index = at;
        o.ok = (kind != KIND_NONE);
      end
      OP_ADD: begin
        if (admin_uid[7:0] == ADMIN_UNSET_BYTE) begin
          admin_uid = r.uid;
          o.ok = 1'b1;
        end else if (find_card(r.uid, at) != KIND_NONE) begin
          o.ok = 1'b0;
        end else if (card_total >= CAL_MAX_CARDS) begin
          o.list_full = 1'b1;
        end else begin
          card_ids[card_total] = r.uid;
          card_total++;
          o.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (find_card(r.uid, at) == KIND_APPROVED) begin
          // move the last entry into the freed slot
          card_total--;
          card_ids[at] = card_ids[card_total];
          o.ok = 1'b1;
        end
      end
      default: begin
        if (r.entry_index < card_total) begin
          o.entry_uid = card_ids[r.entry_index];
          o.ok = 1'b1;
        end
      end
    endcase
    o.card_count = card_total[5:0];
    return o;
  endfunction

  task automatic queue_request(input logic [1:0] op, input logic [31:0] uid,
                               input logic [4:0] idx);
    cal_req_t r;
    r.op = op;
    r.uid = uid;
    r.entry_index = idx;
    req_q.push_back(r);
  endtask

  task automatic plan_directed();
    queue_request(OP_READ, 32'h0, 5'd0);
    queue_request(OP_MATCH, 32'hFFFFFFFF, 5'd0);   // unset admin matches all ones
    queue_request(OP_MATCH, 32'h000000FF, 5'd0);
    queue_request(OP_REMOVE, 32'hFFFFFFFF, 5'd0);
    queue_request(OP_ADD, 32'h123456FF, 5'd0);     // admin set but still reads as unset
    queue_request(OP_MATCH, 32'h123456FF, 5'd0);
    queue_request(OP_ADD, ADMIN_CARD, 5'd0);       // replaces admin
    queue_request(OP_ADD, ADMIN_CARD, 5'd0);
    queue_request(OP_ADD, 32'h00000000, 5'd0);
    queue_request(OP_ADD, 32'hFFFFFFFF, 5'd0);
    queue_request(OP_ADD, 32'h5A5A5A5A, 5'd0);
    queue_request(OP_ADD, 32'h00000000, 5'd0);
    queue_request(OP_MATCH, 32'hFFFFFFFF, 5'd0);
    queue_request(OP_MATCH, 32'h5A5A5A5A, 5'd0);
    queue_request(OP_MATCH, ADMIN_CARD, 5'd0);
    queue_request(OP_READ, 32'h0, 5'd0);
    queue_request(OP_READ, 32'h0, 5'd1);
    queue_request(OP_READ, 32'h0, 5'd2);
    queue_request(OP_READ, 32'h0, 5'd3);
    queue_request(OP_READ, 32'hFFFFFFFF, 5'd31);
    queue_request(OP_REMOVE, ADMIN_CARD, 5'd0);
    queue_request(OP_REMOVE, 32'h12345678, 5'd0);
    queue_request(OP_REMOVE, 32'h00000000, 5'd0);
    queue_request(OP_READ, 32'h0, 5'd0);
    queue_request(OP_MATCH, 32'h5A5A5A5A, 5'd0);
  endtask

  // Alternate fill, drain and mixed stretches so the list hits full and empty.
  task automatic plan_random(input int unsigned n_items);
    logic [31:0] pool[$];
    mix_phase_t  phase;
    int unsigned roll;
    int unsigned pick;
    logic [1:0]  op;
    logic [31:0] id;
    for (int unsigned n = 0; n < n_items; n++) begin
      phase = mix_phase_t'((n / 150) % 3);
      roll = $urandom_range(99);
      case (phase)
        PH_FILL: begin
          op = (roll < 60) ? OP_ADD : (roll < 75) ? OP_MATCH :
               (roll < 85) ? OP_REMOVE : OP_READ;
        end
        PH_DRAIN: begin
          op = (roll < 50) ? OP_REMOVE : (roll < 65) ? OP_ADD :
               (roll < 85) ? OP_MATCH : OP_READ;
        end
        default: begin
          op = roll[1:0];
        end
      endcase
      pick = $urandom_range(99);
      if (op == OP_ADD) begin
        if (pool.size() > 0 && pick < 20) id = pool[$urandom_range(pool.size() - 1)];
        else if (pick < 25) id = ADMIN_CARD;
        else begin
          id = $urandom;
          pool.push_back(id);
          if (pool.size() > 48) void'(pool.pop_front());
        end
      end else begin
        if (pool.size() > 0 && pick < 70) id = pool[$urandom_range(pool.size() - 1)];
        else if (pick < 80) id = ADMIN_CARD;
        else id = $urandom;
      end
      queue_request(op, id, 5'($urandom_range(31)));
    end
  endtask

  // Present the next request; hold it until taken.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        pending_rsps.push_back(apply_card_request(req_q.pop_front()));
        sent_count++;
        offering = 1'b0;
      end
      if (!offering && req_q.size() > 0 &&
          ((sent_count >= 600 && sent_count < 900) || $urandom_range(99) >= 20)) begin
        req <= req_q[0];
        offering = 1'b1;
      end
      start <= offering;
    end
  end

  always @(posedge clk) begin
    cal_rsp_t want;
    if (!rst && done) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected result: %p", rsp);
        fail_count++;
      end else begin
        want = pending_rsps.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, actual %0d", want.ok, rsp.ok);
          fail_count++;
        end
        if (rsp.match_kind !== want.match_kind) begin
          $error("match_kind: expected %0d, actual %0d", want.match_kind, rsp.match_kind);
          fail_count++;
        end
        if (rsp.match_index !== want.match_index) begin
          $error("match_index: expected %0d, actual %0d", want.match_index,
                 rsp.match_index);
          fail_count++;
        end
        if (rsp.card_count !== want.card_count) begin
          $error("card_count: expected %0d, actual %0d", want.card_count, rsp.card_count);
          fail_count++;
        end
        if (rsp.entry_uid !== want.entry_uid) begin
          $error("entry_uid: expected %h, actual %h", want.entry_uid, rsp.entry_uid);
          fail_count++;
        end
        if (rsp.list_full !== want.list_full) begin
          $error("list_full: expected %0d, actual %0d", want.list_full, rsp.list_full);
          fail_count++;
        end
      end
    end
  end

  initial begin
    admin_uid = '1;
    card_total = 0;
    foreach (card_ids[i]) card_ids[i] = '0;
    plan_directed();
    plan_random(RANDOM_REQUESTS);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    do @(posedge clk); while (req_q.size() != 0 || pending_rsps.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
